// ===== design/midi_track_event_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit_assert.svh
// Assertion macros shared by the parser checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define MTEP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed: implication");

// When a request is stalled, it stays up and its payload holds at the next edge.
`define MTEP_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, bits) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(bits))) \
        else $error("parser check failed: stalled request changed");

`endif

// ===== design/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Widths, record codes and the result record type of the track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

    // Longest accepted variable-length quantity, in bytes
    localparam int MAX_VLQ_BYTES = 4;
    localparam int VLQ_CNT_W     = $clog2(MAX_VLQ_BYTES + 1);

    // Field widths
    localparam int ACC_W    = 28;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 7;
    localparam int KIND_W   = 2;
    localparam int ERRC_W   = 2;

    // Record kinds
    localparam logic [KIND_W-1:0] KIND_CHANNEL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_META_HDR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_META_BYTE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

    // Error codes
    localparam logic [ERRC_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERRC_W-1:0] ERR_NO_STATUS = 2'd1;
    localparam logic [ERRC_W-1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [ERRC_W-1:0] ERR_OVERFLOW  = 2'd3;

    // Status values
    localparam logic [BYTE_W-1:0] STATUS_META = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_NONE = 8'h00;
    localparam logic [3:0]        NIB_PROGRAM = 4'hC;
    localparam logic [3:0]        NIB_PRESSURE = 4'hD;

    // One result record
    typedef struct packed {
        logic [KIND_W-1:0] record_kind;
        logic [ACC_W-1:0]  delta_time;
        logic [BYTE_W-1:0] status_byte;
        logic [DATA_W-1:0] first_param;
        logic [DATA_W-1:0] second_param;
        logic [BYTE_W-1:0] meta_kind;
        logic [ACC_W-1:0]  meta_length;
        logic [BYTE_W-1:0] payload_byte;
        logic [ERRC_W-1:0] error_code;
        logic              last_of_event;
    } t_record;

endpackage

`default_nettype wire

// ===== design/mtep_in_if.sv =====
// ----------------------------------------------------------------------------
// mtep_in_if
// Input channel of the parser: one track byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_in_if import mtep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_data;

    modport source (output valid, output byte_in, output end_of_data, input ready);
    modport sink   (input valid, input byte_in, input end_of_data, output ready);
endinterface

`default_nettype wire

// ===== design/mtep_out_if.sv =====
// ----------------------------------------------------------------------------
// mtep_out_if
// Output channel of the parser: one event record per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_out_if import mtep_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] record_kind;
    logic [ACC_W-1:0]  delta_time;
    logic [BYTE_W-1:0] status_byte;
    logic [DATA_W-1:0] first_param;
    logic [DATA_W-1:0] second_param;
    logic [BYTE_W-1:0] meta_kind;
    logic [ACC_W-1:0]  meta_length;
    logic [BYTE_W-1:0] payload_byte;
    logic [ERRC_W-1:0] error_code;
    logic              last_of_event;

    modport source (
        output valid, input ready,
        output record_kind, output delta_time, output status_byte,
        output first_param, output second_param, output meta_kind,
        output meta_length, output payload_byte, output error_code,
        output last_of_event
    );
    modport sink (
        input valid, output ready,
        input record_kind, input delta_time, input status_byte,
        input first_param, input second_param, input meta_kind,
        input meta_length, input payload_byte, input error_code,
        input last_of_event
    );
endinterface

`default_nettype wire

// ===== design/mtep_out_stage.sv =====
// ----------------------------------------------------------------------------
// mtep_out_stage
// Result register: holds one record until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_out_stage import mtep_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_record i_rec,
    output logic         o_free,
    mtep_out_if.source   o_out
);

    logic    r_valid;
    t_record r_rec;

    // Free when empty or when the held record leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_rec <= i_rec;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.record_kind   = r_rec.record_kind;
    assign o_out.delta_time    = r_rec.delta_time;
    assign o_out.status_byte   = r_rec.status_byte;
    assign o_out.first_param   = r_rec.first_param;
    assign o_out.second_param  = r_rec.second_param;
    assign o_out.meta_kind     = r_rec.meta_kind;
    assign o_out.meta_length   = r_rec.meta_length;
    assign o_out.payload_byte  = r_rec.payload_byte;
    assign o_out.error_code    = r_rec.error_code;
    assign o_out.last_of_event = r_rec.last_of_event;

endmodule

`default_nettype wire

// ===== design/midi_track_event_parser_unit.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// MIDI track event parser with running status and meta events.
// ----------------------------------------------------------------------------
// Takes one track byte per cycle and emits at most one record per byte: a
// channel event when its last data byte arrives, a meta header when the meta
// length completes, and one record per meta payload byte. Errors (data with no
// running status, a buffer cut off inside an event, a delta time or meta length
// longer than MAX_VLQ_BYTES) give an error record and return to the delta time.
// Each byte is decoded in the cycle it is accepted and its record appears in
// the result register on the next cycle; the result register lets a new byte
// be taken as a held record leaves, so the sustained rate is one byte per cycle
// whenever the downstream side takes records. Input ready drops only while a
// record is held and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser_unit import mtep_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtep_in_if.sink    i_in,
    mtep_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_PARAM1,
        PH_PARAM2,
        PH_MTYPE,
        PH_MLEN,
        PH_PAYLOAD
    } t_phase;

    t_phase                r_phase,    n_phase;
    logic [ACC_W-1:0]      r_time,     n_time;
    logic [VLQ_CNT_W-1:0]  r_cnt,      n_cnt;
    logic [BYTE_W-1:0]     r_running,  n_running;
    logic [DATA_W-1:0]     r_held_p1,  n_held_p1;
    logic [BYTE_W-1:0]     r_held_meta, n_held_meta;
    logic [ACC_W-1:0]      r_len,      n_len;
    logic [ACC_W-1:0]      r_remain,   n_remain;

    t_record               rec;
    logic                  has_rec;
    logic                  err;
    logic                  accept;
    logic                  out_free;

    logic [BYTE_W-1:0]     b;
    logic [DATA_W-1:0]     data7;
    logic                  vlq_full;
    logic [ACC_W-1:0]      time_shift;
    logic [ACC_W-1:0]      len_shift;
    logic [ACC_W-1:0]      remain_dec;
    logic                  run_one_param;

    assign accept     = i_in.valid && out_free;
    assign i_in.ready = out_free;

    assign b             = i_in.byte_in;
    assign data7         = b[DATA_W-1:0];
    assign vlq_full      = (r_cnt >= VLQ_CNT_W'(MAX_VLQ_BYTES));
    assign time_shift    = {r_time[ACC_W-DATA_W-1:0], data7};
    assign len_shift     = {r_len[ACC_W-DATA_W-1:0], data7};
    assign remain_dec    = r_remain - ACC_W'(1);
    assign run_one_param = (r_running[7:4] == NIB_PROGRAM) ||
                           (r_running[7:4] == NIB_PRESSURE);

    // Next state and record for the byte at the input
    always_comb begin
        n_phase     = r_phase;
        n_time      = r_time;
        n_cnt       = r_cnt;
        n_running   = r_running;
        n_held_p1   = r_held_p1;
        n_held_meta = r_held_meta;
        n_len       = r_len;
        n_remain    = r_remain;
        rec         = '0;
        has_rec     = 1'b0;
        err         = 1'b0;

        case (r_phase)
            PH_DELTA: begin
                if (vlq_full) begin
                    err = 1'b1;
                    rec.error_code = ERR_OVERFLOW;
                end else begin
                    n_cnt  = r_cnt + VLQ_CNT_W'(1);
                    n_time = time_shift;
                    if (!b[7]) begin
                        n_phase = PH_STATUS;
                        n_cnt   = '0;
                    end
                end
            end
            PH_STATUS, PH_PARAM1: begin
                if (r_phase == PH_STATUS && b[7]) begin
                    if (b == STATUS_META) begin
                        n_phase = PH_MTYPE;
                    end else begin
                        n_running = b;
                        n_phase   = PH_PARAM1;
                    end
                end else if (r_phase == PH_STATUS && r_running == STATUS_NONE) begin
                    err = 1'b1;
                    rec.error_code = ERR_NO_STATUS;
                end else begin
                    // first data byte, explicit or running status
                    n_held_p1 = data7;
                    if (run_one_param) begin
                        has_rec            = 1'b1;
                        rec.record_kind    = KIND_CHANNEL;
                        rec.delta_time     = r_time;
                        rec.status_byte    = r_running;
                        rec.first_param    = data7;
                        rec.last_of_event  = 1'b1;
                        n_phase            = PH_DELTA;
                        n_time             = '0;
                        n_cnt              = '0;
                    end else begin
                        n_phase = PH_PARAM2;
                    end
                end
            end
            PH_PARAM2: begin
                has_rec            = 1'b1;
                rec.record_kind    = KIND_CHANNEL;
                rec.delta_time     = r_time;
                rec.status_byte    = r_running;
                rec.first_param    = r_held_p1;
                rec.second_param   = data7;
                rec.last_of_event  = 1'b1;
                n_phase            = PH_DELTA;
                n_time             = '0;
                n_cnt              = '0;
            end
            PH_MTYPE: begin
                n_held_meta = b;
                n_len       = '0;
                n_cnt       = '0;
                n_phase     = PH_MLEN;
            end
            PH_MLEN: begin
                if (vlq_full) begin
                    err = 1'b1;
                    rec.error_code = ERR_OVERFLOW;
                end else begin
                    n_cnt = r_cnt + VLQ_CNT_W'(1);
                    n_len = len_shift;
                    if (!b[7]) begin
                        has_rec         = 1'b1;
                        rec.record_kind = KIND_META_HDR;
                        rec.delta_time  = r_time;
                        rec.status_byte = STATUS_META;
                        rec.meta_kind   = r_held_meta;
                        rec.meta_length = len_shift;
                        n_cnt           = '0;
                        if (len_shift == '0) begin
                            rec.last_of_event = 1'b1;
                            n_phase           = PH_DELTA;
                            n_time            = '0;
                        end else begin
                            n_remain = len_shift;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                n_remain         = remain_dec;
                has_rec          = 1'b1;
                rec.record_kind  = KIND_META_BYTE;
                rec.delta_time   = r_time;
                rec.status_byte  = STATUS_META;
                rec.meta_kind    = r_held_meta;
                rec.meta_length  = r_len;
                rec.payload_byte = b;
                if (remain_dec == '0) begin
                    rec.last_of_event = 1'b1;
                    n_phase           = PH_DELTA;
                    n_time            = '0;
                    n_cnt             = '0;
                end
            end
            default: begin
                n_phase = PH_DELTA;
                n_time  = '0;
                n_cnt   = '0;
            end
        endcase

        // Buffer ends inside an event
        if (!err && i_in.end_of_data && !(n_phase == PH_DELTA && n_cnt == '0)) begin
            err = 1'b1;
            rec = '0;
            rec.error_code = ERR_TRUNCATED;
        end

        // Error record: clear all but kind, code and last flag, back to delta time
        if (err) begin
            has_rec           = 1'b1;
            rec.record_kind   = KIND_ERROR;
            rec.last_of_event = 1'b1;
            n_phase           = PH_DELTA;
            n_time            = '0;
            n_cnt             = '0;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_time      <= '0;
            r_cnt       <= '0;
            r_running   <= STATUS_NONE;
            r_held_p1   <= '0;
            r_held_meta <= '0;
            r_len       <= '0;
            r_remain    <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_time      <= n_time;
            r_cnt       <= n_cnt;
            r_running   <= n_running;
            r_held_p1   <= n_held_p1;
            r_held_meta <= n_held_meta;
            r_len       <= n_len;
            r_remain    <= n_remain;
        end
    end

    // Result register
    mtep_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && has_rec),
        .i_rec   (rec),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== design/mtep_checker.sv =====
// ----------------------------------------------------------------------------
// mtep_checker
// Port-level checks on the parser's result records, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_track_event_parser_unit_assert.svh"

module mtep_checker import mtep_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [KIND_W-1:0] i_record_kind,
    input wire logic [ACC_W-1:0]  i_delta_time,
    input wire logic [BYTE_W-1:0] i_status_byte,
    input wire logic [DATA_W-1:0] i_first_param,
    input wire logic [DATA_W-1:0] i_second_param,
    input wire logic [BYTE_W-1:0] i_meta_kind,
    input wire logic [ACC_W-1:0]  i_meta_length,
    input wire logic [BYTE_W-1:0] i_payload_byte,
    input wire logic [ERRC_W-1:0] i_error_code,
    input wire logic              i_last_of_event
);

    logic [$bits(t_record)-1:0] out_bits;
    logic is_err;
    logic is_chan;
    logic is_meta;

    assign out_bits = {i_record_kind, i_delta_time, i_status_byte, i_first_param,
                       i_second_param, i_meta_kind, i_meta_length, i_payload_byte,
                       i_error_code, i_last_of_event};
    assign is_err  = i_out_valid && (i_record_kind == KIND_ERROR);
    assign is_chan = i_out_valid && (i_record_kind == KIND_CHANNEL);
    assign is_meta = i_out_valid &&
                     ((i_record_kind == KIND_META_HDR) || (i_record_kind == KIND_META_BYTE));

    // A stalled record holds
    `MTEP_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, i_out_valid, i_out_ready, out_bits)

    // Error records carry a code, close the event and nothing else
    `MTEP_ASSERT_IMPLIES(a_err_shape, i_clk, i_rst_n, is_err,
        i_last_of_event && (i_error_code != ERR_NONE) && (i_delta_time == '0) &&
        (i_status_byte == '0) && (i_first_param == '0) && (i_second_param == '0) &&
        (i_meta_kind == '0) && (i_meta_length == '0) && (i_payload_byte == '0))

    // Only error records carry an error code
    `MTEP_ASSERT_IMPLIES(a_code_kind, i_clk, i_rst_n, i_out_valid && !is_err,
        i_error_code == ERR_NONE)

    // Channel events close their event and use a non-meta status
    `MTEP_ASSERT_IMPLIES(a_chan_shape, i_clk, i_rst_n, is_chan,
        i_last_of_event && i_status_byte[7] && (i_status_byte != STATUS_META) &&
        (i_meta_kind == '0) && (i_meta_length == '0) && (i_payload_byte == '0))

    // Meta records show the meta status and no channel data
    `MTEP_ASSERT_IMPLIES(a_meta_shape, i_clk, i_rst_n, is_meta,
        (i_status_byte == STATUS_META) && (i_first_param == '0) &&
        (i_second_param == '0))

endmodule

bind midi_track_event_parser_unit mtep_checker u_mtep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_record_kind   (o_out.record_kind),
    .i_delta_time    (o_out.delta_time),
    .i_status_byte   (o_out.status_byte),
    .i_first_param   (o_out.first_param),
    .i_second_param  (o_out.second_param),
    .i_meta_kind     (o_out.meta_kind),
    .i_meta_length   (o_out.meta_length),
    .i_payload_byte  (o_out.payload_byte),
    .i_error_code    (o_out.error_code),
    .i_last_of_event (o_out.last_of_event)
);

`default_nettype wire
